// File: hw/rtl/char_lcd_command_sequencer_defines.svh
// Assertion macros used by the command sequencer to check its own logic.
`ifndef CHAR_LCD_COMMAND_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_COMMAND_SEQUENCER_DEFINES_SVH

// Antecedent holds in this cycle, consequent in the same cycle.
`define CLCD_ASSERT_NOW(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("clcd: same-cycle check failed");

// Antecedent holds in this cycle, consequent in the next one.
`define CLCD_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("clcd: next-cycle check failed");

`endif

// File: hw/rtl/clcd_pkg.sv
package clcd_pkg;

   // Command codes on the request channel
   localparam logic [2:0] ACT_PUTCHAR     = 3'd0;
   localparam logic [2:0] ACT_CLEAR       = 3'd1;
   localparam logic [2:0] ACT_HOME        = 3'd2;
   localparam logic [2:0] ACT_SET_POS     = 3'd3;
   localparam logic [2:0] ACT_SHIFT_LEFT  = 3'd4;
   localparam logic [2:0] ACT_SHIFT_RIGHT = 3'd5;
   localparam logic [2:0] ACT_OFF         = 3'd6;
   localparam logic [2:0] ACT_ON          = 3'd7;

   // Controller instruction bits
   localparam logic [7:0] CMD_DDRAM     = 8'h80;
   localparam logic [7:0] LINE2_BASE    = 8'h40;
   localparam logic [7:0] CMD_CLEAR     = 8'h01;
   localparam logic [7:0] CMD_HOME      = 8'h02;
   localparam logic [7:0] CMD_SHIFT     = 8'h10;
   localparam logic [7:0] SHIFT_DISPLAY = 8'h08;
   localparam logic [7:0] SHIFT_RIGHT   = 8'h04;
   localparam logic [7:0] CMD_DISPLAY   = 8'h08;
   localparam logic [7:0] DISPLAY_ON    = 8'h04;

   localparam logic [7:0] FIRST_CTRL_END = 8'd80;
   localparam logic [7:0] DUAL_CELLS     = 8'd160;

   // Enable masks
   localparam logic [1:0] EN_FIRST  = 2'b01;
   localparam logic [1:0] EN_SECOND = 2'b10;
   localparam logic [1:0] EN_BOTH   = 2'b11;

   // Register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COLUMNS    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CELL_COUNT = 2'd1;

   localparam logic [5:0] COLUMNS_RESET    = 6'd40;
   localparam logic [7:0] CELL_COUNT_RESET = 8'd160;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] char_code;
      logic [7:0] position;
   } req_type;

   typedef struct packed {
      logic [7:0] bus_byte;
      logic       register_select;
      logic [1:0] enable_mask;
      logic       last;
      logic [7:0] cursor_position;
   } rsp_type;

   // Divider control and status
   typedef struct packed {
      logic       start;
      logic [7:0] dividend;
      logic [5:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic       done;
      logic [7:0] quotient;
      logic [5:0] remainder;
   } div_rsp_type;

endpackage

// File: hw/rtl/char_lcd_command_sequencer.sv
// Character LCD command sequencer.
// The req_ channel takes one command per transaction (put character, clear,
// home, set position, shift, display off or on); the rsp_ channel returns the
// controller bus writes it causes, one or two per command, the final one
// marked by last. The csr_ port writes columns and cell_count; a write to
// either resets the cursor to zero and must be made while the block is idle.
// One command is worked on at a time: req_stall stays high from acceptance
// until its last write has been taken.
// Put character and set position run an 8-step shared divider by the
// column count before their first write; the other commands show their
// write in the cycle after acceptance. A second write follows in the
// cycle after the first is taken.
// Reset restores 40 columns and 160 cells and puts the cursor at zero.
// While rsp_stall is high the pending write holds unchanged and no new
// command is accepted.
`include "char_lcd_command_sequencer_defines.svh"

module char_lcd_command_sequencer
   import clcd_pkg::*;
#(
   parameter int unsigned MAX_COLUMNS = 40
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_type                    rsp_data,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]                 csr_write_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_OUT0 = 2'd2;
   localparam logic [1:0] ST_OUT1 = 2'd3;

   localparam logic [5:0] COL_LIMIT = 6'(MAX_COLUMNS);

   logic [1:0]  state_ff, state_in;
   logic [7:0]  cursor_ff, cursor_in;
   logic [5:0]  columns_ff, columns_in;
   logic [7:0]  cell_count_ff, cell_count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic [7:0]  second_byte_ff, second_byte_in;
   logic        is_put_ff, is_put_in;

   logic        req_accept;
   logic        rsp_accept;
   logic [5:0]  eff_cols;
   logic [7:0]  put_next;
   logic [7:0]  line_y;
   logic [7:0]  line_addr;
   logic [7:0]  pos_byte;
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign req_stall  = state_ff != ST_IDLE;
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Clamp the column count into the supported range
   always_comb begin
      if (columns_ff == 6'd0) begin
         eff_cols = 6'd1;
      end else if (columns_ff > COL_LIMIT) begin
         eff_cols = COL_LIMIT;
      end else begin
         eff_cols = columns_ff;
      end
   end

   // Advance the cursor and wrap at the cell count
   always_comb begin
      put_next = 8'(cursor_ff + 8'd1);
      if (put_next == cell_count_ff) begin
         put_next = 8'd0;
      end
   end

   // Map row and column onto a DDRAM address
   always_comb begin
      line_y = div_rsp.quotient;
      if (cell_count_ff == DUAL_CELLS && line_y > 8'd1) begin
         line_y = 8'(line_y - 8'd2);
      end
      case (line_y)
         8'd0:    line_addr = {2'b00, div_rsp.remainder};
         8'd1:    line_addr = 8'(LINE2_BASE + {2'b00, div_rsp.remainder});
         8'd2:    line_addr = 8'({2'b00, eff_cols} + {2'b00, div_rsp.remainder});
         default: line_addr = 8'(LINE2_BASE + {2'b00, eff_cols}
                                + {2'b00, div_rsp.remainder});
      endcase
      pos_byte = CMD_DDRAM | line_addr;
   end

   // Launch the divider on the operand the command needs
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = req_data.position;
      div_req.divisor  = eff_cols;
      if (req_accept) begin
         if (req_data.action == ACT_PUTCHAR) begin
            div_req.start    = 1'b1;
            div_req.dividend = put_next;
         end else if (req_data.action == ACT_SET_POS) begin
            div_req.start = 1'b1;
         end
      end
   end

   clcd_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Sequence one command through divide and output
   always_comb begin
      state_in       = state_ff;
      cursor_in      = cursor_ff;
      columns_in     = columns_ff;
      cell_count_in  = cell_count_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      second_byte_in = second_byte_ff;
      is_put_in      = is_put_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_data_in.register_select = 1'b0;
               rsp_data_in.enable_mask     = EN_BOTH;
               rsp_data_in.last            = 1'b1;
               rsp_data_in.cursor_position = cursor_ff;
               is_put_in                   = 1'b0;
               state_in                    = ST_OUT1;
               rsp_valid_in                = 1'b1;
               case (req_data.action)
                  ACT_PUTCHAR: begin
                     rsp_data_in.bus_byte        = req_data.char_code;
                     rsp_data_in.register_select = 1'b1;
                     rsp_data_in.enable_mask     = (cursor_ff < FIRST_CTRL_END) ?
                                                   EN_FIRST : EN_SECOND;
                     rsp_data_in.cursor_position = put_next;
                     cursor_in                   = put_next;
                     is_put_in                   = 1'b1;
                     state_in                    = ST_DIV;
                     rsp_valid_in                = 1'b0;
                  end
                  ACT_CLEAR: begin
                     rsp_data_in.bus_byte        = CMD_CLEAR;
                     rsp_data_in.cursor_position = 8'd0;
                     cursor_in                   = 8'd0;
                  end
                  ACT_HOME: begin
                     rsp_data_in.bus_byte        = CMD_HOME;
                     rsp_data_in.cursor_position = 8'd0;
                     cursor_in                   = 8'd0;
                  end
                  ACT_SET_POS: begin
                     rsp_data_in.bus_byte        = CMD_DDRAM;
                     rsp_data_in.cursor_position = req_data.position;
                     cursor_in                   = req_data.position;
                     state_in                    = ST_DIV;
                     rsp_valid_in                = 1'b0;
                  end
                  ACT_SHIFT_LEFT: begin
                     rsp_data_in.bus_byte = CMD_SHIFT | SHIFT_DISPLAY;
                  end
                  ACT_SHIFT_RIGHT: begin
                     rsp_data_in.bus_byte = CMD_SHIFT | SHIFT_DISPLAY | SHIFT_RIGHT;
                  end
                  ACT_OFF: begin
                     rsp_data_in.bus_byte = CMD_DISPLAY;
                  end
                  default: begin
                     rsp_data_in.bus_byte = CMD_DISPLAY | DISPLAY_ON;
                  end
               endcase
            end else if (csr_write_enable) begin
               // Drop writes beyond the register list
               if (csr_index == CSR_COLUMNS) begin
                  columns_in = csr_write_data[5:0];
                  cursor_in  = 8'd0;
               end else if (csr_index == CSR_CELL_COUNT) begin
                  cell_count_in = csr_write_data;
                  cursor_in     = 8'd0;
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               rsp_valid_in = 1'b1;
               if (is_put_ff) begin
                  second_byte_in = pos_byte;
                  if (div_rsp.remainder == 6'd0) begin
                     rsp_data_in.last = 1'b0;
                     state_in         = ST_OUT0;
                  end else begin
                     state_in = ST_OUT1;
                  end
               end else begin
                  rsp_data_in.bus_byte = pos_byte;
                  state_in             = ST_OUT1;
               end
            end
         end
         ST_OUT0: begin
            // Hand over the row-start address write once the data is taken
            if (rsp_accept) begin
               rsp_data_in.bus_byte        = second_byte_ff;
               rsp_data_in.register_select = 1'b0;
               rsp_data_in.enable_mask     = EN_BOTH;
               rsp_data_in.last            = 1'b1;
               state_in                    = ST_OUT1;
            end
         end
         default: begin
            if (rsp_accept) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cursor_ff     <= 8'd0;
         columns_ff    <= COLUMNS_RESET;
         cell_count_ff <= CELL_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
         is_put_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_ff     <= cursor_in;
         columns_ff    <= columns_in;
         cell_count_ff <= cell_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         is_put_ff     <= is_put_in;
      end
      rsp_data_ff    <= rsp_data_in;
      second_byte_ff <= second_byte_in;
   end

   `CLCD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept, req_stall)
   `CLCD_ASSERT_NOW(a_done_only_in_div, clock, reset, div_rsp.done, state_ff == ST_DIV)
   `CLCD_ASSERT_NOW(a_not_last_means_second, clock, reset,
      rsp_valid_ff && !rsp_data_ff.last, state_ff == ST_OUT0)
   `CLCD_ASSERT_NOW(a_valid_only_when_out, clock, reset, rsp_valid_ff,
      state_ff == ST_OUT0 || state_ff == ST_OUT1)

endmodule

// File: hw/rtl/clcd_divider.sv
module clcd_divider
   import clcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   logic [2:0] count_ff, count_in;
   logic [5:0] rem_ff, rem_in;
   logic [7:0] quo_ff, quo_in;
   logic [5:0] divisor_ff, divisor_in;
   logic [6:0] trial;
   logic       fits;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, quo_ff[7]};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = 3'd0;
         rem_in     = 6'd0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? 6'(trial - {1'b0, divisor_ff}) : trial[5:0];
         quo_in   = {quo_ff[6:0], fits};
         count_in = 3'(count_ff + 3'd1);
         if (count_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= 3'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule
